// ===== rtl/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;
    localparam int MaxOrder  = 11;
    localparam int ZonePages = 4096;
    localparam int ZoneCount = 2;
    localparam int IdxW      = $clog2(ZonePages);
    localparam int OrdW      = 4;
    localparam int ZoneW     = 1;
    localparam int PageAw    = ZoneW + IdxW;
    localparam int LimW      = IdxW + 1;
    localparam int ListN     = ZoneCount * MaxOrder;
    localparam logic [OrdW-1:0] NotFree = OrdW'(MaxOrder);

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;
    localparam logic StatDone = 1'b0;
    localparam logic StatFail = 1'b1;
    localparam logic [0:0] RegNormalPages = 1'b0;
    localparam logic [0:0] RegHighPages   = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic            zone_select;
        logic [OrdW-1:0] block_order;
        logic [IdxW-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic            status;
        logic [IdxW-1:0] result_index;
        logic [OrdW-1:0] result_order;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_REM_RD,
        ST_REM_WAIT,
        ST_REM_FIX,
        ST_SPLIT,
        ST_APP,
        ST_FREE_CHK,
        ST_BUD_RD,
        ST_BUD_WAIT,
        ST_BUD_CHK,
        ST_FIN_APP,
        ST_RESP
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/bpa_ram.sv =====
`default_nettype none
module bpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
// Buddy page allocator over two zones of 4096 pages.
// Requests arrive as transfers on the s_ channel (allocate or free, zone,
// order, index) and each yields exactly one result transfer on the m_
// channel (status, block start, block order).
// Tags and page links live in single-port-write RAMs with registered reads;
// the per-order list heads, tails and non-empty bits are flops.
// One request is worked on at a time. An allocate takes longer the more
// it splits and a free the more it merges; each step of the loop over
// orders is a read-modify-write of the tag and link RAMs.
// After reset the block sweeps the tag RAM to the "not free" value, one
// entry a cycle, while s_ready stays low; configuration writes are taken
// during that sweep.
// The result is held in an output register; while the receiver stalls, the
// block waits with s_ready low until the result transfer completes.
`default_nettype none
module buddy_page_allocator (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bpa_pkg::req_t         s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bpa_pkg::rsp_t              m_data,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [12:0]           cfg_wdata
);
    import bpa_pkg::*;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    rsp_t   rsp_reg, rsp_next;
    logic   mv_reg, mv_next;
    logic [PageAw-1:0] clr_reg, clr_next;
    logic [LimW-1:0] lim_reg [ZoneCount];
    logic [OrdW-1:0] cur_reg, cur_next;
    logic [IdxW-1:0] pg_reg, pg_next;
    logic [IdxW-1:0] bud_reg, bud_next;
    logic [IdxW-1:0] nx_reg, nx_next, pv_reg, pv_next;
    logic [IdxW-1:0] head_reg [ListN], tail_reg [ListN];
    logic [ListN-1:0] used_reg;

    logic            tag_we, nl_we, pl_we;
    logic [PageAw-1:0] tag_wa, tag_ra, nl_wa, nl_ra, pl_wa, pl_ra;
    logic [OrdW-1:0] tag_wd, tag_rd;
    logic [IdxW-1:0] nl_wd, nl_rd, pl_wd, pl_rd;

    bpa_ram #(.Width(OrdW), .Depth(2**PageAw)) u_tag (
        .aclk(aclk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .raddr(tag_ra), .rdata(tag_rd));
    bpa_ram #(.Width(IdxW), .Depth(2**PageAw)) u_next (
        .aclk(aclk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
        .raddr(nl_ra), .rdata(nl_rd));
    bpa_ram #(.Width(IdxW), .Depth(2**PageAw)) u_prev (
        .aclk(aclk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
        .raddr(pl_ra), .rdata(pl_rd));

    logic [4:0]      lidx;
    logic [4:0]      lz;
    logic            zs;
    logic [IdxW-1:0] split_b;
    logic [LimW-1:0] lim_eff;
    logic [LimW-1:0] bud_w;
    logic            l_used;
    logic [IdxW-1:0] l_head, l_tail;
    logic            app_en, rem_en, rem_last;
    logic [OrdW-1:0] app_ord;
    logic [IdxW-1:0] app_pg;
    logic [4:0]      app_l;
    logic [OrdW-1:0] cur_dec;

    assign zs      = req_reg.zone_select;
    assign lz      = zs ? 5'(MaxOrder) : 5'd0;
    assign lidx    = lz + 5'(cur_reg);
    assign l_used  = used_reg[lidx];
    assign l_head  = head_reg[lidx];
    assign l_tail  = tail_reg[lidx];
    assign cur_dec = cur_reg - OrdW'(1);
    assign split_b = pg_reg ^ (IdxW'(1) << cur_dec);
    assign lim_eff = (lim_reg[zs] < LimW'(ZonePages)) ? lim_reg[zs] : LimW'(ZonePages);
    assign bud_w   = {1'b0, bud_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ZoneCount; i++) begin
                lim_reg[i] <= LimW'(ZonePages);
            end
        end else if (cfg_we) begin
            lim_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (req_reg.block_order >= OrdW'(MaxOrder)) state_next = ST_RESP;
                else if (req_reg.cmd == CmdAlloc) state_next = ST_SEARCH;
                else state_next = ST_FREE_CHK;
            end
            ST_SEARCH: begin
                if (l_used) state_next = ST_REM_RD;
                else if (cur_reg == OrdW'(MaxOrder - 1)) state_next = ST_RESP;
            end
            ST_REM_RD:   state_next = ST_REM_WAIT;
            ST_REM_WAIT: state_next = ST_REM_FIX;
            ST_REM_FIX: begin
                if (req_reg.cmd == CmdFree) state_next = ST_BUD_CHK;
                else if (cur_reg == req_reg.block_order) state_next = ST_RESP;
                else state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (cur_dec == req_reg.block_order) state_next = ST_RESP;
            end
            ST_APP:      state_next = ST_RESP;
            ST_FREE_CHK: begin
                if (tag_rd != NotFree) state_next = ST_RESP;
                else state_next = ST_BUD_RD;
            end
            ST_BUD_RD:   state_next = ST_BUD_WAIT;
            ST_BUD_WAIT: begin
                if (cur_reg == OrdW'(MaxOrder - 1) || bud_w >= lim_eff ||
                    tag_rd != cur_reg) state_next = ST_FIN_APP;
                else state_next = ST_REM_RD;
            end
            ST_BUD_CHK:  state_next = ST_BUD_RD;
            ST_FIN_APP:  state_next = ST_RESP;
            ST_RESP:     if (mv_reg && m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        req_next = req_reg;
        rsp_next = rsp_reg;
        mv_next  = mv_reg;
        clr_next = clr_reg;
        cur_next = cur_reg;
        pg_next  = pg_reg;
        bud_next = bud_reg;
        nx_next  = nx_reg;
        pv_next  = pv_reg;
        tag_we = 1'b0; tag_wa = '0; tag_wd = NotFree;
        nl_we = 1'b0; nl_wa = '0; nl_wd = '0;
        pl_we = 1'b0; pl_wa = '0; pl_wd = '0;
        tag_ra = {zs, pg_reg};
        nl_ra  = {zs, pg_reg};
        pl_ra  = {zs, pg_reg};
        app_en = 1'b0; app_ord = cur_reg; app_pg = pg_reg;
        rem_en = 1'b0; rem_last = 1'b0;

        if (m_valid && m_ready) mv_next = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                tag_we = 1'b1; tag_wa = clr_reg; tag_wd = NotFree;
                clr_next = clr_reg + PageAw'(1);
            end
            ST_IDLE: begin
                req_next = s_data;
                cur_next = s_data.block_order;
                pg_next  = s_data.block_index;
                tag_ra   = {s_data.zone_select, s_data.block_index};
            end
            ST_DECODE: begin
                rsp_next = '{status: StatFail, result_index: '0, result_order: '0};
                tag_ra = {zs, pg_reg};
            end
            ST_SEARCH: begin
                if (l_used) begin
                    pg_next = l_head;
                    bud_next = l_head;
                end else if (cur_reg != OrdW'(MaxOrder - 1)) begin
                    cur_next = cur_reg + OrdW'(1);
                end
            end
            ST_REM_RD: begin
                nl_ra = {zs, bud_reg};
                pl_ra = {zs, bud_reg};
                tag_we = 1'b1; tag_wa = {zs, bud_reg}; tag_wd = NotFree;
            end
            ST_REM_WAIT: begin
                nx_next = nl_rd;
                pv_next = pl_rd;
            end
            ST_REM_FIX: begin
                rem_en = l_used;
                if (l_used) begin
                    if (l_head == bud_reg && l_tail == bud_reg) begin
                        rem_last = 1'b1;
                    end else begin
                        if (l_head != bud_reg) begin
                            nl_we = 1'b1; nl_wa = {zs, pv_reg}; nl_wd = nx_reg;
                        end
                        if (l_tail != bud_reg) begin
                            pl_we = 1'b1; pl_wa = {zs, nx_reg}; pl_wd = pv_reg;
                        end
                    end
                end
                if (req_reg.cmd == CmdFree) begin
                    cur_next = cur_reg + OrdW'(1);
                    if (bud_reg < pg_reg) pg_next = bud_reg;
                end else if (cur_reg == req_reg.block_order) begin
                    rsp_next = '{status: StatDone, result_index: pg_reg,
                                 result_order: req_reg.block_order};
                    mv_next = 1'b1;
                end
            end
            ST_SPLIT: begin
                app_en = 1'b1; app_ord = cur_dec; app_pg = split_b;
                cur_next = cur_dec;
                if (cur_dec == req_reg.block_order) begin
                    rsp_next = '{status: StatDone, result_index: pg_reg,
                                 result_order: req_reg.block_order};
                    mv_next = 1'b1;
                end
            end
            ST_APP: begin
            end
            ST_FREE_CHK: begin
                bud_next = pg_reg ^ (IdxW'(1) << cur_reg);
                tag_ra = {zs, pg_reg ^ (IdxW'(1) << cur_reg)};
            end
            ST_BUD_RD: begin
                tag_ra = {zs, bud_reg};
            end
            ST_BUD_WAIT: begin
                tag_ra = {zs, bud_reg};
            end
            ST_BUD_CHK: begin
                bud_next = pg_reg ^ (IdxW'(1) << cur_reg);
            end
            ST_FIN_APP: begin
                app_en = 1'b1; app_ord = cur_reg; app_pg = pg_reg;
                rsp_next = '{status: StatDone, result_index: pg_reg, result_order: cur_reg};
                mv_next = 1'b1;
            end
            ST_RESP: begin
                if (!mv_reg && rsp_reg.status == StatFail) mv_next = 1'b1;
            end
            default: begin
            end
        endcase

        app_l = lz + 5'(app_ord);
        if (app_en) begin
            tag_we = 1'b1; tag_wa = {zs, app_pg}; tag_wd = app_ord;
            if (used_reg[app_l]) begin
                nl_we = 1'b1; nl_wa = {zs, tail_reg[app_l]}; nl_wd = app_pg;
                pl_we = 1'b1; pl_wa = {zs, app_pg}; pl_wd = tail_reg[app_l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mv_reg    <= 1'b0;
            clr_reg   <= '0;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            clr_reg   <= clr_next;
            if (rem_en) begin
                if (rem_last) begin
                    used_reg[lidx] <= 1'b0;
                end else begin
                    if (l_head == bud_reg) head_reg[lidx] <= nx_reg;
                    if (l_tail == bud_reg) tail_reg[lidx] <= pv_reg;
                end
            end
            if (app_en) begin
                if (!used_reg[app_l]) begin
                    head_reg[app_l] <= app_pg;
                    used_reg[app_l] <= 1'b1;
                end
                tail_reg[app_l] <= app_pg;
            end
        end
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        cur_reg <= cur_next;
        pg_reg  <= pg_next;
        bud_reg <= bud_next;
        nx_reg  <= nx_next;
        pv_reg  <= pv_next;
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_checker.sv =====
`default_nettype none
module bpa_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire bpa_pkg::rsp_t m_data
);
    import bpa_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == StatFail |-> m_data.result_index == '0)
        else $error("failed result carries an index");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
`default_nettype wire
